### sv/ppc_pkg.sv
// Package for the point projection colorizer: shared constants, register
// indexes, command codes and the configuration struct.
// No dependencies.
package ppc_pkg;

    // Default geometry and number format
    localparam int MAX_WIDTH_DEF     = 1024;
    localparam int MAX_HEIGHT_DEF    = 1024;
    localparam int FRACTION_BITS_DEF = 16;

    // Range limit in whole meters, compared squared
    localparam int RANGE_LIMIT_M = 58;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Stream payload widths
    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 120;

    // Configuration port address width
    localparam int CFG_ADDR_W = 5;

    // Command codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_POINT = 1'b1;

    // Register indexes
    localparam logic [2:0] REG_FOCAL_X  = 3'd0;
    localparam logic [2:0] REG_CENTER_X = 3'd1;
    localparam logic [2:0] REG_FOCAL_Y  = 3'd2;
    localparam logic [2:0] REG_CENTER_Y = 3'd3;
    localparam logic [2:0] REG_WIDTH    = 3'd4;
    localparam logic [2:0] REG_HEIGHT   = 3'd5;
    localparam logic [2:0] REG_CHANNELS = 3'd6;

    // Configuration registers as seen by front and back
    typedef struct packed {
        logic signed [31:0] focal_x;
        logic signed [31:0] center_x;
        logic signed [31:0] focal_y;
        logic signed [31:0] center_y;
        logic        [10:0] image_width;
        logic        [10:0] image_height;
        logic        [1:0]  channel_count;
    } t_cfg;

endpackage

### sv/ppc_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
module ppc_ram #(
    parameter int W     = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/ppc_div.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// No dependencies; used by ppc_front for each projection axis.
module ppc_div #(
    parameter int PW = 53,
    parameter int DW = 22
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [PW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [PW-1:0] o_quo,
    output logic          o_rem_nz
);

    logic [DW-1:0] r_rem [PW];
    logic [PW-1:0] r_num [PW];
    logic [PW-1:0] r_quo [PW];
    logic [DW-1:0] r_den [PW];

    logic [DW-1:0] in_rem [PW];
    logic [PW-1:0] in_num [PW];
    logic [PW-1:0] in_quo [PW];
    logic [DW-1:0] in_den [PW];
    logic [DW:0]   w_trial [PW];
    logic          w_ge [PW];
    logic [DW-1:0] n_rem [PW];
    logic [PW-1:0] n_num [PW];
    logic [PW-1:0] n_quo [PW];

    // Stage inputs: stage 0 from the ports, others from the stage before
    always_comb begin
        in_rem[0] = '0;
        in_num[0] = i_num;
        in_quo[0] = '0;
        in_den[0] = i_den;
        for (int k = 1; k < PW; k++) begin
            in_rem[k] = r_rem[k-1];
            in_num[k] = r_num[k-1];
            in_quo[k] = r_quo[k-1];
            in_den[k] = r_den[k-1];
        end
    end

    // One trial subtract per stage
    always_comb begin
        for (int k = 0; k < PW; k++) begin
            w_trial[k] = {in_rem[k], in_num[k][PW-1]};
            w_ge[k]    = (w_trial[k] >= {1'b0, in_den[k]});
            n_rem[k]   = w_ge[k] ? DW'(w_trial[k] - {1'b0, in_den[k]})
                                 : w_trial[k][DW-1:0];
            n_num[k]   = {in_num[k][PW-2:0], 1'b0};
            n_quo[k]   = {in_quo[k][PW-2:0], w_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < PW; k++) begin
                r_rem[k] <= n_rem[k];
                r_num[k] <= n_num[k];
                r_quo[k] <= n_quo[k];
                r_den[k] <= in_den[k];
            end
        end
    end

    assign o_quo    = r_quo[PW-1];
    assign o_rem_nz = |r_rem[PW-1];

endmodule

### sv/ppc_front.sv
// Front part: accepts words, range-checks points, projects them through two
// pipelined dividers and forms the pixel address. Depends on ppc_pkg, ppc_div.
module ppc_front #(
    parameter int MAX_WIDTH     = 1024,
    parameter int MAX_HEIGHT    = 1024,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_en,
    input  ppc_pkg::t_cfg                             i_cfg,
    input  logic                                      i_valid,
    input  logic                                      i_cmd,
    input  logic signed [31:0]                        i_x,
    input  logic signed [31:0]                        i_y,
    input  logic signed [31:0]                        i_z,
    input  logic [9:0]                                i_col,
    input  logic [9:0]                                i_row,
    input  logic [7:0]                                i_b0,
    input  logic [7:0]                                i_b1,
    input  logic [7:0]                                i_b2,
    output logic                                      o_push,
    output logic                                      o_is_pt,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]   o_addr,
    output logic [31:0]                               o_x,
    output logic [31:0]                               o_y,
    output logic [31:0]                               o_z
);
    import ppc_pkg::*;

    // Coordinate magnitude after the range check, product and address widths
    localparam int CW = FRACTION_BITS + 6;
    localparam int PW = 31 + CW;
    localparam int AW = $clog2(MAX_WIDTH*MAX_HEIGHT);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam logic [63:0] LIM2 =
        64'(RANGE_LIMIT_M*RANGE_LIMIT_M) << (2*FRACTION_BITS);

    typedef struct packed {
        logic        vld;
        logic        pt;
        logic        keep;
        logic        neg_u;
        logic        neg_v;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [9:0]  col;
        logic [9:0]  row;
    } t_side;

    // Stage 1: squares and focal products
    logic               r1_vld, r1_pt, r1_wkeep;
    logic signed [31:0] r1_x, r1_y, r1_z;
    logic [9:0]         r1_col, r1_row;
    logic [63:0]        r1_sqx, r1_sqy, r1_sqz;
    logic signed [63:0] r1_pu, r1_pv;

    logic signed [63:0] w_xe, w_ye, w_ze;

    assign w_xe = 64'(i_x);
    assign w_ye = 64'(i_y);
    assign w_ze = 64'(i_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pt    <= (i_cmd == CMD_POINT);
            r1_wkeep <= ({22'b0, i_col} < 32'(MAX_WIDTH))
                     && ({22'b0, i_row} < 32'(MAX_HEIGHT));
            r1_x     <= (i_cmd == CMD_POINT) ? i_x : {8'h00, i_b2, i_b1, i_b0};
            r1_y     <= i_y;
            r1_z     <= i_z;
            r1_col   <= i_col;
            r1_row   <= i_row;
            r1_sqx   <= 64'(w_xe * w_xe);
            r1_sqy   <= 64'(w_ye * w_ye);
            r1_sqz   <= 64'(w_ze * w_ze);
            r1_pu    <= 64'(i_cfg.focal_x) * w_xe;
            r1_pv    <= 64'(i_cfg.focal_y) * w_ye;
        end
    end

    // Stage 2: range test, magnitudes and quotient signs
    t_side              r2_side;
    logic [PW-1:0]      r2_mu, r2_mv;
    logic [CW-1:0]      r2_mz;
    logic [63:0]        w_sum;
    logic signed [63:0] w_apu, w_apv;
    logic signed [31:0] w_az;
    logic               w_pkeep;

    assign w_sum   = r1_sqx + r1_sqy + r1_sqz;
    assign w_apu   = r1_pu[63] ? -r1_pu : r1_pu;
    assign w_apv   = r1_pv[63] ? -r1_pv : r1_pv;
    assign w_az    = r1_z[31] ? -r1_z : r1_z;
    assign w_pkeep = (w_sum <= LIM2) && (r1_z != 32'sd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_side.vld <= 1'b0;
        end else if (i_en) begin
            r2_side.vld <= r1_vld;
        end
        if (i_en) begin
            r2_side.pt    <= r1_pt;
            r2_side.keep  <= r1_pt ? w_pkeep : r1_wkeep;
            r2_side.neg_u <= r1_pu[63] ^ r1_z[31];
            r2_side.neg_v <= r1_pv[63] ^ r1_z[31];
            r2_side.x     <= r1_x;
            r2_side.y     <= r1_y;
            r2_side.z     <= r1_z;
            r2_side.col   <= r1_col;
            r2_side.row   <= r1_row;
            r2_mu         <= PW'(w_apu);
            r2_mv         <= PW'(w_apv);
            r2_mz         <= CW'(w_az);
        end
    end

    // Divider pipelines with a matching sideband delay line
    logic [PW-1:0] w_quo_u, w_quo_v;
    logic          w_rnz_u, w_rnz_v;
    t_side         r_sd [PW];

    ppc_div #(.PW(PW), .DW(CW)) u_div_u (
        .i_clk    (i_clk),
        .i_en     (i_en),
        .i_num    (r2_mu),
        .i_den    (r2_mz),
        .o_quo    (w_quo_u),
        .o_rem_nz (w_rnz_u)
    );

    ppc_div #(.PW(PW), .DW(CW)) u_div_v (
        .i_clk    (i_clk),
        .i_en     (i_en),
        .i_num    (r2_mv),
        .i_den    (r2_mz),
        .o_quo    (w_quo_v),
        .o_rem_nz (w_rnz_v)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PW; k++) begin
                r_sd[k] <= '0;
            end
        end else if (i_en) begin
            r_sd[0] <= r2_side;
            for (int k = 1; k < PW; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // F1: floored signed quotient; -Q-1 is ~Q
    t_side              rf1_side;
    logic signed [PW:0] rf1_qu, rf1_qv;
    logic signed [PW:0] w_qu, w_qv;

    always_comb begin
        w_qu = $signed({1'b0, w_quo_u});
        w_qv = $signed({1'b0, w_quo_v});
        if (r_sd[PW-1].neg_u) begin
            w_qu = w_rnz_u ? ~w_qu : -w_qu;
        end
        if (r_sd[PW-1].neg_v) begin
            w_qv = w_rnz_v ? ~w_qv : -w_qv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rf1_side <= '0;
        end else if (i_en) begin
            rf1_side <= r_sd[PW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            rf1_qu <= w_qu;
            rf1_qv <= w_qv;
        end
    end

    // F2: add principal point
    t_side                rf2_side;
    logic signed [PW+1:0] rf2_u, rf2_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rf2_side <= '0;
        end else if (i_en) begin
            rf2_side <= rf1_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            rf2_u <= (PW+2)'(rf1_qu) + (PW+2)'(i_cfg.center_x);
            rf2_v <= (PW+2)'(rf1_qv) + (PW+2)'(i_cfg.center_y);
        end
    end

    // F3: bounds, pixel index and store address
    logic [31:0]   w_wmin, w_hmin;
    logic [PW+1:0] w_lim_u, w_lim_v;
    logic          w_in_u, w_in_v, w_keep3;
    logic [XW-1:0] w_col;
    logic [YW-1:0] w_row;
    logic [AW-1:0] w_addr;

    assign w_wmin = ({21'b0, i_cfg.image_width} < 32'(MAX_WIDTH))
                  ? {21'b0, i_cfg.image_width} : 32'(MAX_WIDTH);
    assign w_hmin = ({21'b0, i_cfg.image_height} < 32'(MAX_HEIGHT))
                  ? {21'b0, i_cfg.image_height} : 32'(MAX_HEIGHT);
    assign w_lim_u = (PW+2)'(w_wmin) << FRACTION_BITS;
    assign w_lim_v = (PW+2)'(w_hmin) << FRACTION_BITS;
    assign w_in_u  = !rf2_u[PW+1] && ($unsigned(rf2_u) < w_lim_u);
    assign w_in_v  = !rf2_v[PW+1] && ($unsigned(rf2_v) < w_lim_v);
    assign w_keep3 = rf2_side.pt ? (rf2_side.keep && w_in_u && w_in_v)
                                 : rf2_side.keep;
    assign w_col   = rf2_side.pt ? rf2_u[FRACTION_BITS+XW-1:FRACTION_BITS]
                                 : XW'(rf2_side.col);
    assign w_row   = rf2_side.pt ? rf2_v[FRACTION_BITS+YW-1:FRACTION_BITS]
                                 : YW'(rf2_side.row);
    assign w_addr  = AW'(w_row) * AW'(MAX_WIDTH) + AW'(w_col);

    logic          r3_vld, r3_keep, r3_pt;
    logic [AW-1:0] r3_addr;
    logic [31:0]   r3_x, r3_y, r3_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld  <= 1'b0;
            r3_keep <= 1'b0;
        end else if (i_en) begin
            r3_vld  <= rf2_side.vld;
            r3_keep <= w_keep3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_pt   <= rf2_side.pt;
            r3_addr <= w_addr;
            r3_x    <= rf2_side.x;
            r3_y    <= rf2_side.y;
            r3_z    <= rf2_side.z;
        end
    end

    assign o_push  = r3_vld && r3_keep;
    assign o_is_pt = r3_pt;
    assign o_addr  = r3_addr;
    assign o_x     = r3_x;
    assign o_y     = r3_y;
    assign o_z     = r3_z;

endmodule

### sv/ppc_fifo.sv
// Short register queue between the front and the back parts.
// No dependencies.
module ppc_fifo #(
    parameter int W     = 117,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);

    localparam int PTW = $clog2(DEPTH);

    logic [W-1:0] r_mem [DEPTH];
    logic [PTW:0] r_wr, r_rd;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr[PTW-1:0]] <= i_data;
        end
    end

    // Pointers with a wrap bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    assign o_data  = r_mem[r_rd[PTW-1:0]];
    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[PTW] != r_rd[PTW]) && (r_wr[PTW-1:0] == r_rd[PTW-1:0]);

endmodule

### sv/ppc_back.sv
// Back part: writes pixels, reads colors for points and holds the result.
// Depends on ppc_pkg and ppc_ram.
module ppc_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  ppc_pkg::t_cfg                           i_cfg,
    input  logic                                    i_empty,
    input  logic                                    i_is_pt,
    input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] i_addr,
    input  logic [31:0]                             i_x,
    input  logic [31:0]                             i_y,
    input  logic [31:0]                             i_z,
    output logic                                    o_pop,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic [31:0]                             o_x,
    output logic [31:0]                             o_y,
    output logic [31:0]                             o_z,
    output logic [7:0]                              o_c0,
    output logic [7:0]                              o_c1,
    output logic [7:0]                              o_c2
);
    import ppc_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam logic [1:0] CH_ONE = 2'd1;
    localparam logic [1:0] CH_TWO = 2'd2;

    logic        w_we, w_re;
    logic [23:0] w_rdata;
    logic        r_out_vld;
    logic [31:0] r_x, r_y, r_z;

    // A point pops only when the result slot frees; a pixel write always can
    assign o_pop = !i_empty && (!i_is_pt || !r_out_vld || i_ready);
    assign w_we  = o_pop && !i_is_pt;
    assign w_re  = o_pop && i_is_pt;

    ppc_ram #(.W(24), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_addr),
        .i_wdata (i_x[23:0]),
        .i_re    (w_re),
        .i_raddr (i_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_re) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_x <= i_x;
            r_y <= i_y;
            r_z <= i_z;
        end
    end

    // Channel handling on the held read word
    always_comb begin
        o_c0 = w_rdata[7:0];
        o_c1 = w_rdata[15:8];
        o_c2 = w_rdata[23:16];
        case (i_cfg.channel_count)
            CH_ONE: begin
                o_c1 = w_rdata[7:0];
                o_c2 = w_rdata[7:0];
            end
            CH_TWO: begin
                o_c2 = 8'h00;
            end
            default: begin
            end
        endcase
    end

    assign o_valid = r_out_vld;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

    // At most one RAM access per cycle
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_we, w_re}))
        else $error("RAM write and read in one cycle");

    // A read always lands in the result slot
    a_read_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_re |=> r_out_vld)
        else $error("read did not fill result slot");

    // Never pop an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_empty)
        else $error("queue underflow");

endmodule

### sv/point_projection_colorizer.sv
// Throughput: one word per cycle on the input stream while the output drains.
// A point passes through the bit-per-stage dividers of the projection.
// Pixel writes pass through the same pipeline, so reads and writes keep order.
// Reset (synchronous, active low) clears control state and sets registers to
// their defaults; pixel store contents are undefined until written.
module point_projection_colorizer #(
    parameter int MAX_WIDTH     = ppc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT    = ppc_pkg::MAX_HEIGHT_DEF,
    parameter int FRACTION_BITS = ppc_pkg::FRACTION_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // point_x, point_y, point_z, pixel_column, pixel_row,
    // byte_zero, byte_one, byte_two, zero fill
    input  logic [ppc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // command
    input  logic [0:0]                      s_axis_tuser,
    // master stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_x, out_y, out_z, color_zero, color_one, color_two
    output logic [ppc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ppc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import ppc_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH*MAX_HEIGHT);
    localparam int FW = 1 + AW + 96;

    // Configuration registers
    t_cfg       r_cfg;
    logic [2:0] w_idx;

    assign w_idx  = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal_x       <= 32'sd1 <<< FRACTION_BITS;
            r_cfg.center_x      <= '0;
            r_cfg.focal_y       <= 32'sd1 <<< FRACTION_BITS;
            r_cfg.center_y      <= '0;
            r_cfg.image_width   <= 11'd1024;
            r_cfg.image_height  <= 11'd1024;
            r_cfg.channel_count <= 2'd3;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_idx)
                REG_FOCAL_X:  r_cfg.focal_x       <= pwdata;
                REG_CENTER_X: r_cfg.center_x      <= pwdata;
                REG_FOCAL_Y:  r_cfg.focal_y       <= pwdata;
                REG_CENTER_Y: r_cfg.center_y      <= pwdata;
                REG_WIDTH:    r_cfg.image_width   <= pwdata[10:0];
                REG_HEIGHT:   r_cfg.image_height  <= pwdata[10:0];
                REG_CHANNELS: r_cfg.channel_count <= pwdata[1:0];
                default: begin
                end
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (w_idx)
            REG_FOCAL_X:  prdata = r_cfg.focal_x;
            REG_CENTER_X: prdata = r_cfg.center_x;
            REG_FOCAL_Y:  prdata = r_cfg.focal_y;
            REG_CENTER_Y: prdata = r_cfg.center_y;
            REG_WIDTH:    prdata = {21'b0, r_cfg.image_width};
            REG_HEIGHT:   prdata = {21'b0, r_cfg.image_height};
            REG_CHANNELS: prdata = {30'b0, r_cfg.channel_count};
            default:      prdata = '0;
        endcase
    end

    // Front pipeline advances while the queue has room
    logic          w_en, w_full, w_empty, w_fpush, w_pop;
    logic          w_f_pt;
    logic [AW-1:0] w_f_addr;
    logic [31:0]   w_f_x, w_f_y, w_f_z;
    logic [FW-1:0] w_q_in, w_q_out;

    assign w_en          = !w_full;
    assign s_axis_tready = w_en;

    ppc_front #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .i_cmd   (s_axis_tuser[0]),
        .i_x     (s_axis_tdata[31:0]),
        .i_y     (s_axis_tdata[63:32]),
        .i_z     (s_axis_tdata[95:64]),
        .i_col   (s_axis_tdata[105:96]),
        .i_row   (s_axis_tdata[115:106]),
        .i_b0    (s_axis_tdata[123:116]),
        .i_b1    (s_axis_tdata[131:124]),
        .i_b2    (s_axis_tdata[139:132]),
        .o_push  (w_fpush),
        .o_is_pt (w_f_pt),
        .o_addr  (w_f_addr),
        .o_x     (w_f_x),
        .o_y     (w_f_y),
        .o_z     (w_f_z)
    );

    assign w_q_in = {w_f_pt, w_f_addr, w_f_z, w_f_y, w_f_x};

    ppc_fifo #(.W(FW), .DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fpush && w_en),
        .i_data  (w_q_in),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    logic [31:0] w_ox, w_oy, w_oz;
    logic [7:0]  w_c0, w_c1, w_c2;

    ppc_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (w_empty),
        .i_is_pt (w_q_out[FW-1]),
        .i_addr  (w_q_out[FW-2:96]),
        .i_x     (w_q_out[31:0]),
        .i_y     (w_q_out[63:32]),
        .i_z     (w_q_out[95:64]),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_x     (w_ox),
        .o_y     (w_oy),
        .o_z     (w_oz),
        .o_c0    (w_c0),
        .o_c1    (w_c1),
        .o_c2    (w_c2)
    );

    assign m_axis_tdata = {w_c2, w_c1, w_c0, w_oz, w_oy, w_ox};

endmodule
